[design/tagged_priority_request_queue_top_macros.svh]
// Assertion macros shared by the request queue RTL.
// No dependencies; taken in by the files that carry concurrent checks.
`ifndef TAGGED_PRIORITY_REQUEST_QUEUE_TOP_MACROS_SVH
`define TAGGED_PRIORITY_REQUEST_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TPQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TPQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tpq_pkg.sv]
// Shared types and constants of the request queue.
// No dependencies; used by the interfaces and every module.
`default_nettype none

package tpq_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned PRIO_W  = 2;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE = 2'd0,
    OP_TAKE    = 2'd1,
    OP_FIND    = 2'd2,
    OP_REMOVE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [ID_W-1:0]   requester;
    logic [PRIO_W-1:0] priority_level;
    logic [ID_W-1:0]   resource;
  } entry_t;

endpackage

`default_nettype wire

[design/tpq_if.sv]
// Request and result channel interfaces with valid/ready handshake.
// Depends on tpq_pkg for field widths.
`default_nettype none

interface tpq_req_if;
  logic                             valid;
  logic                             ready;
  logic [tpq_pkg::OP_W-1:0]         op;
  logic [tpq_pkg::ID_W-1:0]         requester_id;
  logic [tpq_pkg::PRIO_W-1:0]       priority_level;
  logic [tpq_pkg::ID_W-1:0]         resource_id;

  modport source (output valid, op, requester_id, priority_level, resource_id,
                  input ready);
  modport sink   (input valid, op, requester_id, priority_level, resource_id,
                  output ready);
endinterface

interface tpq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             success;
  logic [tpq_pkg::ID_W-1:0]         found_requester;
  logic [tpq_pkg::PRIO_W-1:0]       found_priority;
  logic [tpq_pkg::ID_W-1:0]         found_resource;
  logic [tpq_pkg::COUNT_W-1:0]      entry_count;

  modport source (output valid, success, found_requester, found_priority,
                  found_resource, entry_count, input ready);
  modport sink   (input valid, success, found_requester, found_priority,
                  found_resource, entry_count, output ready);
endinterface

`default_nettype wire

[design/tpq_mem.sv]
// Slot memory: one write port, one read port with registered read data.
// Depends on tpq_pkg for the entry type.
`default_nettype none

module tpq_mem #(
  parameter int unsigned QUEUE_DEPTH = 16,
  localparam int unsigned IDXW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [IDXW-1:0] waddr,
  input  wire tpq_pkg::entry_t wdata,
  input  wire logic            re,
  input  wire logic [IDXW-1:0] raddr,
  output tpq_pkg::entry_t      rdata
);

  tpq_pkg::entry_t slots [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      slots[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= slots[raddr];
    end
  end

endmodule

`default_nettype wire

[design/tpq_ctrl.sv]
// Sequencer: scans the slot memory, closes gaps after a removal, holds the result.
// Depends on tpq_pkg, tpq_if and the assertion macro header.
`default_nettype none

`include "tagged_priority_request_queue_top_macros.svh"

module tpq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = 16,
  localparam int unsigned IDXW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int unsigned CNTW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  tpq_req_if.sink              req,
  tpq_rsp_if.source            rsp,
  output logic                 mem_we,
  output logic [IDXW-1:0]      mem_waddr,
  output tpq_pkg::entry_t      mem_wdata,
  output logic                 mem_re,
  output logic [IDXW-1:0]      mem_raddr,
  input  wire tpq_pkg::entry_t mem_rdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FINISH
  } state_t;

  state_t          state;
  tpq_pkg::op_t    op;
  tpq_pkg::entry_t key;
  logic [CNTW-1:0] count;
  logic [CNTW-1:0] rd_idx;
  logic [CNTW-1:0] cmp_idx;
  logic            cmp_vld;
  logic            hit;
  logic            ok;
  logic [IDXW-1:0] best_idx;
  tpq_pkg::entry_t best;

  logic                         out_valid;
  logic                         out_success;
  tpq_pkg::entry_t              out_entry;
  logic [tpq_pkg::COUNT_W-1:0]  out_count;

  logic            full;
  logic            issue;
  logic            res_eq;
  logic            req_eq;
  logic            cur_match;
  logic            better;
  logic            hit_next;
  tpq_pkg::entry_t best_next;
  logic [IDXW-1:0] best_idx_next;
  logic            scan_end;
  logic            more;
  logic [CNTW-1:0] shift_waddr;
  logic            show;

  assign full   = (count >= CNTW'(QUEUE_DEPTH));
  assign more   = (rd_idx < count);
  assign issue  = more && (state == ST_SHIFT ||
                           (state == ST_SCAN && op != tpq_pkg::OP_ENQUEUE));

  assign res_eq = (mem_rdata.resource == key.resource);
  assign req_eq = (mem_rdata.requester == key.requester);
  assign cur_match = cmp_vld && res_eq && (op != tpq_pkg::OP_REMOVE || req_eq);
  // First match wins, except take-highest replaces on a strictly lower level.
  assign better = cur_match && (!hit || (op == tpq_pkg::OP_TAKE &&
                  mem_rdata.priority_level < best.priority_level));
  assign hit_next      = hit || cur_match;
  assign best_next     = better ? mem_rdata : best;
  assign best_idx_next = better ? cmp_idx[IDXW-1:0] : best_idx;
  assign scan_end      = !more || (op != tpq_pkg::OP_TAKE && cur_match);

  assign shift_waddr = cmp_idx - CNTW'(1);

  always_comb begin
    mem_re    = issue;
    mem_raddr = rd_idx[IDXW-1:0];
    if (state == ST_SHIFT) begin
      mem_we    = cmp_vld;
      mem_waddr = shift_waddr[IDXW-1:0];
      mem_wdata = mem_rdata;
    end else begin
      mem_we    = (state == ST_SCAN) && (op == tpq_pkg::OP_ENQUEUE) && !full;
      mem_waddr = count[IDXW-1:0];
      mem_wdata = key;
    end
  end

  assign show = ok && (op == tpq_pkg::OP_TAKE || op == tpq_pkg::OP_FIND);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      cmp_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            op                 <= tpq_pkg::op_t'(req.op);
            key.requester      <= req.requester_id;
            key.priority_level <= req.priority_level;
            key.resource       <= req.resource_id;
            rd_idx             <= '0;
            cmp_vld            <= 1'b0;
            hit                <= 1'b0;
            state              <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (op == tpq_pkg::OP_ENQUEUE) begin
            ok <= !full;
            if (!full) begin
              count <= count + CNTW'(1);
            end
            state <= ST_FINISH;
          end else begin
            cmp_vld  <= issue;
            cmp_idx  <= rd_idx;
            if (issue) begin
              rd_idx <= rd_idx + CNTW'(1);
            end
            hit      <= hit_next;
            best     <= best_next;
            best_idx <= best_idx_next;
            if (scan_end) begin
              ok      <= hit_next;
              cmp_vld <= 1'b0;
              if (hit_next && op != tpq_pkg::OP_FIND) begin
                // close the gap: copy each later slot one place down
                rd_idx <= CNTW'(best_idx_next) + CNTW'(1);
                state  <= ST_SHIFT;
              end else begin
                state <= ST_FINISH;
              end
            end
          end
        end
        ST_SHIFT: begin
          cmp_vld <= issue;
          cmp_idx <= rd_idx;
          if (issue) begin
            rd_idx <= rd_idx + CNTW'(1);
          end
          if (!more) begin
            count   <= count - CNTW'(1);
            cmp_vld <= 1'b0;
            state   <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_success <= ok;
            out_entry   <= show ? best : '0;
            out_count   <= tpq_pkg::COUNT_W'(count);
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign req.ready           = (state == ST_IDLE);
  assign rsp.valid           = out_valid;
  assign rsp.success         = out_success;
  assign rsp.found_requester = out_entry.requester;
  assign rsp.found_priority  = out_entry.priority_level;
  assign rsp.found_resource  = out_entry.resource;
  assign rsp.entry_count     = out_count;

  `TPQ_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CNTW'(QUEUE_DEPTH), "count above depth")
  `TPQ_ASSERT_NXT(a_accept_scan, clk, rst, req.valid && state == ST_IDLE, state == ST_SCAN, "accept did not start scan")
  `TPQ_ASSERT_IMP(a_write_range, clk, rst, mem_we, CNTW'(mem_waddr) <= count, "slot write beyond tail")
  `TPQ_ASSERT_IMP(a_result_src, clk, rst, $rose(out_valid), $past(state) == ST_FINISH, "result loaded outside finish")

endmodule

`default_nettype wire

[design/tagged_priority_request_queue_top.sv]
// Operation: an enqueue writes at the tail; find, take and remove scan one slot a cycle,
//   and a take or remove that hits then copies each later slot one place down to close
//   the gap.
// Throughput: one request in flight; the one-slot-a-cycle scan sets the pace.
// Reset: synchronous, active high; clears the entry count and handshake state.
//   Slot contents are not cleared and are only read below the entry count.
`default_nettype none

module tagged_priority_request_queue_top #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  tpq_req_if.sink    req,
  tpq_rsp_if.source  rsp
);

  localparam int unsigned IDXW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Slot memory port signals between the sequencer and the storage.
  logic            mem_we;
  logic [IDXW-1:0] mem_waddr;
  tpq_pkg::entry_t mem_wdata;
  logic            mem_re;
  logic [IDXW-1:0] mem_raddr;
  tpq_pkg::entry_t mem_rdata;

  // Sequencer: accept a request, scan the slots in arrival order, pick the
  // match, close the gap on removal and hold the result until taken.
  tpq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Storage: one slot per queued request, read data registered.
  tpq_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire
